[design/djs_pkg.sv]
// Shared types for the deadline job scheduler.
// No dependencies. The interface and the top level use these types.
package djs_pkg;

    typedef struct packed {
        logic [15:0] job_profit;
        logic [7:0]  job_deadline;
        logic        last_job;
    } t_job_beat;

    typedef struct packed {
        logic [6:0]  slot_number;
        logic [5:0]  job_index;
        logic        slot_filled;
        logic [15:0] slot_profit;
        logic [21:0] profit_sum;
        logic        last_result;
        logic        job_overflow;
    } t_slot_beat;

endpackage

[design/djs_stream_if.sv]
// Valid/ready stream channel that carries one payload of type T.
// Depends on nothing; the payload types come from djs_pkg.
interface djs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/djs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module djs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/djs_cell.sv]
// One cell of the sorted job chain: holds one job and either clears it, keeps it,
// takes the new job, takes the left neighbour's job (insert) or the right's (pop).
// No dependencies.
module djs_cell #(
    parameter int PW = 16,
    parameter int DW = 7,
    parameter int IW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_insert,
    input  logic                   i_pop,
    input  logic [PW+DW+IW:0]      i_new,
    input  logic [PW+DW+IW:0]      i_prev,
    input  logic                   i_prev_keep,
    input  logic [PW+DW+IW:0]      i_next,
    output logic [PW+DW+IW:0]      o_entry,
    output logic                   o_keep
);
    localparam int EW = 1 + PW + DW + IW;

    logic [EW-1:0] r_e;
    logic [EW-1:0] n_e;

    // stable order: an equal profit already held stays ahead of the new job
    assign o_keep = r_e[EW-1] && (r_e[EW-2 -: PW] >= i_new[EW-2 -: PW]);

    always_comb begin
        n_e = r_e;
        if (i_clear) begin
            n_e = '0;
        end else if (i_pop) begin
            n_e = i_next;
        end else if (i_insert && !o_keep) begin
            n_e = i_prev_keep ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
        end else begin
            r_e <= n_e;
        end
    end

    assign o_entry = r_e;
endmodule

[design/deadline_job_scheduler.sv]
// Deadline job scheduler: greedy job sequencing with deadlines.
// Channels: i_job (sink) takes one job per beat: profit, deadline, last_job.
// o_slot (source) gives one beat per slot 1..largest deadline, or a single
// beat with slot_number 0 when no job has a non-zero deadline.
// Loading (ST_LOAD): one job per cycle; jobs go into a row of MAX_JOBS cells
// that keeps them sorted by profit (highest first, ties in arrival order).
// Scheduling: after the job marked last, the head of the row is taken one
// job at a time (ST_PICK); ST_SEARCH then probes the slots on the walk down
// from its deadline and takes the first free one, or drops the job when
// no free slot is left. It ends when the row is empty, or early once every
// slot holds a job.
// Output: each slot beat goes through slot RAM read, result register and beat
// (ST_OUT_RD/WAIT/SHOW); a low o_slot.ready holds the current beat unchanged.
// i_job.ready is low from the last job until the final slot beat is taken;
// the block then clears its load state and accepts a new job set.
// Reset (i_rst_n low, synchronous) empties the job row and all slot flags.
module deadline_job_scheduler #(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_DEADLINE = 64,
    parameter int PROFIT_BITS  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    djs_stream_if.sink      i_job,
    djs_stream_if.source    o_slot
);
    localparam int PW = PROFIT_BITS;
    localparam int DW = $clog2(MAX_DEADLINE + 1);
    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int TW = PW + DW;
    localparam int EW = 1 + PW + DW + IW;
    localparam int RW = IW + PW;

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_PICK     = 3'd1;
    localparam logic [2:0] ST_SEARCH   = 3'd2;
    localparam logic [2:0] ST_OUT_RD   = 3'd3;
    localparam logic [2:0] ST_OUT_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT_SHOW = 3'd5;
    localparam logic [2:0] ST_NO_SLOT  = 3'd6;

    logic [2:0]            r_state;
    logic [CW-1:0]         r_loaded;
    logic [DW-1:0]         r_largest;
    logic                  r_ovf;
    logic [DW-1:0]         r_filled;
    logic [TW-1:0]         r_total;
    logic [DW-1:0]         r_s;
    logic [IW-1:0]         r_job_idx;
    logic [PW-1:0]         r_job_prof;
    logic [DW-1:0]         r_slot;
    logic [MAX_DEADLINE:0] r_sv;
    djs_pkg::t_slot_beat   r_out;
    logic                  r_out_vld;

    logic [PW-1:0]  in_prof;
    logic [DW-1:0]  in_dl;
    logic           accept;
    logic           insert;
    logic           pop;
    logic           clear;
    logic           done;
    logic [EW-1:0]  new_entry;
    logic [EW-1:0]  entry [MAX_JOBS];
    logic           keep  [MAX_JOBS];
    logic           h_v;
    logic [PW-1:0]  h_p;
    logic [DW-1:0]  h_d;
    logic [IW-1:0]  h_i;
    logic           ram_we;
    logic [RW-1:0]  ram_rdata;
    logic           sv_now;

    generate
        if (PW <= 16) begin : g_prof_narrow
            assign in_prof = i_job.data.job_profit[PW-1:0];
        end else begin : g_prof_wide
            assign in_prof = {{(PW-16){1'b0}}, i_job.data.job_profit};
        end
    endgenerate

    assign in_dl = ({24'd0, i_job.data.job_deadline} > 32'(MAX_DEADLINE))
                   ? DW'(MAX_DEADLINE) : DW'(i_job.data.job_deadline);

    assign i_job.ready = (r_state == ST_LOAD);
    assign accept      = i_job.valid && (r_state == ST_LOAD);
    assign insert      = accept && (r_loaded < CW'(MAX_JOBS));
    assign new_entry   = {1'b1, in_prof, in_dl, IW'(r_loaded)};

    assign h_v = entry[0][EW-1];
    assign h_p = entry[0][EW-2 -: PW];
    assign h_d = entry[0][IW +: DW];
    assign h_i = entry[0][IW-1:0];

    assign pop   = (r_state == ST_PICK) && h_v && (r_filled != r_largest);
    assign done  = (r_state == ST_OUT_SHOW) && o_slot.ready && r_out.last_result;
    assign clear = done;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
            logic [EW-1:0] prev_e;
            logic          prev_k;
            logic [EW-1:0] next_e;
            if (gi == 0) begin : g_head
                assign prev_e = '0;
                assign prev_k = 1'b1;
            end else begin : g_body
                assign prev_e = entry[gi-1];
                assign prev_k = keep[gi-1];
            end
            if (gi == MAX_JOBS - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = entry[gi+1];
            end
            djs_cell #(.PW(PW), .DW(DW), .IW(IW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_clear     (clear),
                .i_insert    (insert),
                .i_pop       (pop),
                .i_new       (new_entry),
                .i_prev      (prev_e),
                .i_prev_keep (prev_k),
                .i_next      (next_e),
                .o_entry     (entry[gi]),
                .o_keep      (keep[gi])
            );
        end
    endgenerate

    assign sv_now = r_sv[r_s];
    assign ram_we = (r_state == ST_SEARCH) && (r_s != '0) && !sv_now;

    djs_ram #(.WIDTH(RW), .DEPTH(MAX_DEADLINE + 1)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s),
        .i_wdata ({r_job_idx, r_job_prof}),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_loaded  <= '0;
            r_largest <= '0;
            r_ovf     <= 1'b0;
            r_filled  <= '0;
            r_total   <= '0;
            r_sv      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (insert) begin
                            r_loaded <= r_loaded + CW'(1);
                            if (in_dl > r_largest) begin
                                r_largest <= in_dl;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_job.data.last_job) begin
                            if (insert && in_dl > r_largest) begin
                                r_state <= ST_PICK;
                            end else if (r_largest != '0) begin
                                r_state <= ST_PICK;
                            end else begin
                                r_state <= ST_NO_SLOT;
                            end
                        end
                    end
                end
                ST_PICK: begin
                    if (pop) begin
                        r_s        <= h_d;
                        r_job_idx  <= h_i;
                        r_job_prof <= h_p;
                        r_state    <= ST_SEARCH;
                    end else begin
                        r_slot  <= DW'(1);
                        r_state <= ST_OUT_RD;
                    end
                end
                ST_SEARCH: begin
                    if (r_s == '0) begin
                        r_state <= ST_PICK;
                    end else if (!sv_now) begin
                        r_sv[r_s] <= 1'b1;
                        r_filled  <= r_filled + DW'(1);
                        r_total   <= r_total + TW'(r_job_prof);
                        r_state   <= ST_PICK;
                    end else begin
                        r_s <= r_s - DW'(1);
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    r_out.slot_number  <= 7'(r_slot);
                    r_out.slot_filled  <= r_sv[r_slot];
                    r_out.job_index    <= r_sv[r_slot] ? 6'(ram_rdata[RW-1 -: IW]) : '0;
                    r_out.slot_profit  <= r_sv[r_slot] ? 16'(ram_rdata[PW-1:0]) : '0;
                    r_out.profit_sum   <= 22'(r_total);
                    r_out.last_result  <= (r_slot == r_largest);
                    r_out.job_overflow <= r_ovf;
                    r_out_vld          <= 1'b1;
                    r_state            <= ST_OUT_SHOW;
                end
                ST_NO_SLOT: begin
                    r_out.slot_number  <= '0;
                    r_out.slot_filled  <= 1'b0;
                    r_out.job_index    <= '0;
                    r_out.slot_profit  <= '0;
                    r_out.profit_sum   <= '0;
                    r_out.last_result  <= 1'b1;
                    r_out.job_overflow <= r_ovf;
                    r_out_vld          <= 1'b1;
                    r_state            <= ST_OUT_SHOW;
                end
                ST_OUT_SHOW: begin
                    if (o_slot.ready) begin
                        r_out_vld <= 1'b0;
                        if (r_out.last_result) begin
                            // drop the whole set and reopen for loading
                            r_loaded  <= '0;
                            r_largest <= '0;
                            r_ovf     <= 1'b0;
                            r_filled  <= '0;
                            r_total   <= '0;
                            r_sv      <= '0;
                            r_state   <= ST_LOAD;
                        end else begin
                            r_slot  <= r_slot + DW'(1);
                            r_state <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_slot.valid = r_out_vld;
    assign o_slot.data  = r_out;

    a_vld_only_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot.valid |-> (r_state == ST_OUT_SHOW))
        else $error("result beat outside the output state");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= r_largest)
        else $error("more slots filled than exist");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_job.ready && o_slot.valid))
        else $error("loading while a result is pending");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_slot.valid && o_slot.ready && o_slot.data.last_result)
        |=> (r_loaded == '0 && r_sv == '0 && !r_ovf))
        else $error("load state not cleared after the final slot");
endmodule

[bench/tb_top.sv]
// Testbench for the deadline job scheduler: directed and random job sets.
// Depends on djs_pkg, djs_stream_if and deadline_job_scheduler.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_JOBS     = 64;
    localparam int MAX_DEADLINE = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    djs_stream_if #(.T(djs_pkg::t_job_beat))  job_ch ();
    djs_stream_if #(.T(djs_pkg::t_slot_beat)) slot_ch ();

    deadline_job_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch),
        .o_slot  (slot_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: the job set being loaded
    logic [15:0] set_profit [MAX_JOBS];
    logic [6:0]  set_deadline [MAX_JOBS];
    int          set_count;
    int          set_largest;
    bit          set_overflow;

    djs_pkg::t_slot_beat slot_queue [$];
    int          mismatches;
    int          beats_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    task automatic clear_set();
        set_count    = 0;
        set_largest  = 0;
        set_overflow = 0;
    endtask

    // greedy sequencing of the loaded set into expected slot beats
    task automatic schedule_set();
        int                  order [MAX_JOBS];
        logic [5:0]          owner [MAX_DEADLINE+1];
        bit                  taken [MAX_DEADLINE+1];
        int                  i, j, s, filled;
        logic [21:0]         total;
        djs_pkg::t_slot_beat b;
        filled = 0;
        total  = '0;
        for (i = 0; i < set_count; i++) begin
            j = i;
            while (j > 0 && set_profit[order[j-1]] < set_profit[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i <= MAX_DEADLINE; i++) taken[i] = 0;
        for (i = 0; i < set_count && set_largest > 0; i++) begin
            s = set_deadline[order[i]];
            while (s >= 1) begin
                if (!taken[s]) begin
                    taken[s] = 1;
                    owner[s] = 6'(order[i]);
                    filled++;
                    break;
                end
                s--;
            end
            if (filled == set_largest) break;
        end
        for (i = 1; i <= set_largest; i++)
            if (taken[i]) total += 22'(set_profit[owner[i]]);
        if (set_largest == 0) begin
            b = '0;
            b.last_result  = 1'b1;
            b.job_overflow = set_overflow;
            slot_queue.push_back(b);
        end else begin
            for (i = 1; i <= set_largest; i++) begin
                b.slot_number  = 7'(i);
                b.job_index    = taken[i] ? owner[i] : '0;
                b.slot_filled  = taken[i];
                b.slot_profit  = taken[i] ? set_profit[owner[i]] : '0;
                b.profit_sum   = total;
                b.last_result  = (i == set_largest);
                b.job_overflow = set_overflow;
                slot_queue.push_back(b);
            end
        end
        clear_set();
    endtask

    task automatic predict_job(djs_pkg::t_job_beat jb);
        int dl;
        dl = (jb.job_deadline > MAX_DEADLINE) ? MAX_DEADLINE : jb.job_deadline;
        if (set_count < MAX_JOBS) begin
            set_profit[set_count]   = jb.job_profit;
            set_deadline[set_count] = 7'(dl);
            set_count++;
            if (dl > set_largest) set_largest = dl;
        end else begin
            set_overflow = 1;
        end
        if (jb.last_job) schedule_set();
    endtask

    // drive one job beat from a falling edge after any random idle gaps, hold until accepted
    task automatic send_job(logic [15:0] profit, logic [7:0] deadline, bit last);
        djs_pkg::t_job_beat jb;
        jb.job_profit   = profit;
        jb.job_deadline = deadline;
        jb.last_job     = last;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            job_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        job_ch.valid <= 1'b1;
        job_ch.data  <= jb;
        do @(posedge i_clk); while (!job_ch.ready);
        predict_job(jb);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        job_ch.valid <= 1'b0;
        while (slot_queue.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_deadline();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'($urandom_range(255, 65));
            2: return 8'd64;
            default: return 8'($urandom_range(12, 1));
        endcase
    endfunction

    // one random set of n jobs: deadlines mostly short, a few long
    task automatic send_random_set(int n);
        int k;
        for (k = 0; k < n; k++)
            send_job(16'($urandom), rand_deadline(), k == n - 1);
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) slot_ch.ready <= 1'b0;
        else slot_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        djs_pkg::t_slot_beat want, got;
        if (i_rst_n && slot_ch.valid && slot_ch.ready) begin
            got = slot_ch.data;
            beats_seen++;
            if (slot_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected slot beat %p", got);
            end else begin
                want = slot_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("slot beat mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_job(16'd0, 8'd0, 1);                // no slots
        send_job(16'hFFFF, 8'd255, 1);           // saturated deadline
        send_job(16'd5, 8'd2, 0);                // ties and zero deadline
        send_job(16'd5, 8'd2, 0);
        send_job(16'd5, 8'd2, 0);
        send_job(16'd9, 8'd0, 0);
        send_job(16'd1, 8'd3, 1);                // every slot ends up filled
        send_job(16'hAAAA, 8'h55, 0);
        send_job(16'h5555, 8'hAA, 0);
        send_job(16'h8000, 8'd1, 0);
        send_job(16'h0001, 8'd128, 1);
        wait_drained();
    endtask

    task automatic test_overflow();
        int k;
        for (k = 0; k < MAX_JOBS + 3; k++)
            send_job(16'($urandom), 8'($urandom_range(8, 1)), k == MAX_JOBS + 2);
        wait_drained();
    endtask

    task automatic test_random(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 1);
            send_random_set(n);
            sent += n;
        end
        wait_drained();
    endtask

    // stall the output for a long stretch while a second job set is offered
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                send_random_set(6);
                send_random_set(4);
            end
        join
        wait_drained();
    endtask

    initial begin
        job_ch.valid   = 1'b0;
        job_ch.data    = '0;
        slot_ch.ready  = 1'b0;
        mismatches     = 0;
        beats_seen     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 0;
        clear_set();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_random(16);
        send_idle_pct = 47;
        test_random(16);
        send_idle_pct = 0; recv_stall_pct = 47;
        test_random(16);
        send_idle_pct = 19; recv_stall_pct = 19;
        test_random(16);
        test_backpressure();

        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && slot_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
